/* sv/gtd_pkg.sv */
// shared types, widths and codes of the grid tile decomposer
package gtd_pkg;

  localparam int unsigned NPW        = 9;   // processor count width
  localparam int unsigned RANK_W     = 8;   // rank and neighbour id width
  localparam int unsigned FIELD_W    = 16;  // tile size and origin width
  localparam int unsigned SIDES_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_NUM_PROCS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd2;

  // datapath operations
  typedef logic [3:0] dp_op_t;
  localparam dp_op_t OP_NOP      = 4'd0;
  localparam dp_op_t OP_LOAD     = 4'd1;
  localparam dp_op_t OP_DEC_C    = 4'd2;
  localparam dp_op_t OP_INC_R    = 4'd3;
  localparam dp_op_t OP_MUL_RH   = 4'd4;
  localparam dp_op_t OP_MUL_CW   = 4'd5;
  localparam dp_op_t OP_ABSDIFF  = 4'd6;
  localparam dp_op_t OP_MUL_LHS  = 4'd7;
  localparam dp_op_t OP_MUL_RHS  = 4'd8;
  localparam dp_op_t OP_UPDATE   = 4'd9;
  localparam dp_op_t OP_DIV_RANK = 4'd10;
  localparam dp_op_t OP_DIV_X0   = 4'd11;
  localparam dp_op_t OP_DIV_X1   = 4'd12;
  localparam dp_op_t OP_DIV_Y0   = 4'd13;
  localparam dp_op_t OP_DIV_Y1   = 4'd14;
  localparam dp_op_t OP_FINISH   = 4'd15;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic rank_err;   // rank not below processor count
    logic r_gt_p;     // row candidate past processor count
    logic prod_gt;    // rows * cols above processor count
    logic prod_eq;    // rows * cols equal to processor count
    logic div_done;   // divider result ready
  } dp_stat_t;

endpackage

/* sv/gtd_div.sv */
// restoring divider, one quotient bit per cycle
module gtd_div #(
  parameter int unsigned DVW = 25,
  parameter int unsigned DSW = 9
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [DVW-1:0] quotient,
  output logic [DSW-1:0] remainder
);

  localparam int unsigned CW = $clog2(DVW + 1);

  logic           busy_r;
  logic           done_r;
  logic [CW-1:0]  cnt_r;
  logic [DVW-1:0] quo_r;
  logic [DSW-1:0] rem_r;
  logic [DSW-1:0] dsr_r;
  logic [DSW:0]   trial;
  logic [DSW:0]   diff;
  logic           fits;

  assign trial = {rem_r, quo_r[DVW-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DVW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVW-2:0], fits};
      rem_r <= fits ? diff[DSW-1:0] : trial[DSW-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* sv/gtd_dp.sv */
// datapath: divisor pair search registers, shared multiplier, divider, result register
module gtd_dp #(
  parameter int unsigned MAX_PROCS = 256,
  parameter int unsigned DW        = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  gtd_pkg::dp_cmd_t                 cmd,
  output gtd_pkg::dp_stat_t                stat,
  input  logic [gtd_pkg::RANK_W-1:0]       in_rank,
  input  logic [gtd_pkg::NPW-1:0]          num_procs,
  input  logic [DW-1:0]                    dim_w,
  input  logic [DW-1:0]                    dim_h,
  output logic [gtd_pkg::RANK_W-1:0]       out_row_index,
  output logic [gtd_pkg::RANK_W-1:0]       out_col_index,
  output logic [gtd_pkg::RANK_W-1:0]       out_east_id,
  output logic [gtd_pkg::RANK_W-1:0]       out_west_id,
  output logic [gtd_pkg::RANK_W-1:0]       out_south_id,
  output logic [gtd_pkg::RANK_W-1:0]       out_north_id,
  output logic [gtd_pkg::FIELD_W-1:0]      out_tile_width,
  output logic [gtd_pkg::FIELD_W-1:0]      out_tile_height,
  output logic [gtd_pkg::FIELD_W-1:0]      out_origin_x,
  output logic [gtd_pkg::FIELD_W-1:0]      out_origin_y,
  output logic [gtd_pkg::SIDES_W-1:0]      out_interior_sides,
  output logic                             out_rank_error
);
  import gtd_pkg::*;

  localparam int unsigned DVW  = DW + NPW;
  localparam int unsigned PW   = DVW + NPW;
  localparam int unsigned RW   = NPW + 1;
  localparam int unsigned PMAX = (2 ** NPW) - 1;
  localparam int unsigned PCAP = (MAX_PROCS < PMAX) ? MAX_PROCS : PMAX;

  // query and search state
  logic [RANK_W-1:0] rank_r;
  logic [NPW-1:0]    p_r;
  logic [DW-1:0]     w_r;
  logic [DW-1:0]     h_r;
  logic [RW-1:0]     r_r;
  logic [NPW-1:0]    c_r;
  logic [RW-1:0]     rc_r;
  logic              first_r;
  logic [NPW-1:0]    best_rows_r;
  logic [NPW-1:0]    best_cols_r;
  logic [DVW-1:0]    best_d_r;
  logic [DVW-1:0]    d_r;
  logic [DVW-1:0]    rh_r;
  logic [PW-1:0]     prod_r;
  logic [PW-1:0]     lhs_r;
  logic [RANK_W-1:0] row_r;
  logic [RANK_W-1:0] col_r;
  logic [DW-1:0]     x0_r;
  logic [DW-1:0]     x1_r;
  logic [DW-1:0]     y0_r;
  logic [DW-1:0]     y1_r;
  dp_op_t            div_op_r;

  // result register
  logic [RANK_W-1:0]  row_out_r;
  logic [RANK_W-1:0]  col_out_r;
  logic [RANK_W-1:0]  east_out_r;
  logic [RANK_W-1:0]  west_out_r;
  logic [RANK_W-1:0]  south_out_r;
  logic [RANK_W-1:0]  north_out_r;
  logic [FIELD_W-1:0] tw_out_r;
  logic [FIELD_W-1:0] th_out_r;
  logic [FIELD_W-1:0] ox_out_r;
  logic [FIELD_W-1:0] oy_out_r;
  logic [SIDES_W-1:0] sides_out_r;
  logic               err_out_r;

  logic [NPW-1:0] p_cap;
  logic [DVW-1:0] mul_a;
  logic [NPW-1:0] mul_b;
  logic [PW-1:0]  mul_p;
  logic           div_start;
  logic [DVW-1:0] div_dividend;
  logic [NPW-1:0] div_divisor;
  logic           div_done;
  logic [DVW-1:0] div_quo;
  logic [NPW-1:0] div_rem;
  logic           rank_err;

  logic [NPW-1:0] rank9;
  logic [NPW-1:0] row9;
  logic [NPW-1:0] col9;
  logic [NPW-1:0] base9;
  logic [NPW-1:0] east9;
  logic [NPW-1:0] west9;
  logic [NPW-1:0] south9;
  logic [NPW-1:0] north9;
  logic [SIDES_W-1:0] sides;

  assign p_cap = (num_procs > NPW'(PCAP)) ? NPW'(PCAP) : num_procs;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MUL_RH: begin
        mul_a = DVW'(h_r);
        mul_b = r_r[NPW-1:0];
      end
      OP_MUL_CW: begin
        mul_a = DVW'(w_r);
        mul_b = c_r;
      end
      OP_MUL_LHS: begin
        mul_a = d_r;
        mul_b = best_cols_r;
      end
      OP_MUL_RHS: begin
        mul_a = best_d_r;
        mul_b = c_r;
      end
      OP_DIV_X0: begin
        mul_a = DVW'(w_r);
        mul_b = NPW'(col_r);
      end
      OP_DIV_X1: begin
        mul_a = DVW'(w_r);
        mul_b = NPW'(col_r) + NPW'(1);
      end
      OP_DIV_Y0: begin
        mul_a = DVW'(h_r);
        mul_b = NPW'(row_r);
      end
      OP_DIV_Y1: begin
        mul_a = DVW'(h_r);
        mul_b = NPW'(row_r) + NPW'(1);
      end
      default: begin
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  assign div_start = (cmd.op == OP_DIV_RANK) || (cmd.op == OP_DIV_X0) ||
                     (cmd.op == OP_DIV_X1) || (cmd.op == OP_DIV_Y0) ||
                     (cmd.op == OP_DIV_Y1);
  assign div_dividend = (cmd.op == OP_DIV_RANK) ? DVW'(rank_r) : mul_p[DVW-1:0];
  assign div_divisor  = ((cmd.op == OP_DIV_Y0) || (cmd.op == OP_DIV_Y1)) ?
                        best_rows_r : best_cols_r;

  gtd_div #(
    .DVW(DVW),
    .DSW(NPW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // neighbours and interior sides
  always_comb begin
    rank9  = NPW'(rank_r);
    row9   = NPW'(row_r);
    col9   = NPW'(col_r);
    base9  = rank9 - col9;
    east9  = base9 + (((col9 + NPW'(1)) == best_cols_r) ? NPW'(0) : (col9 + NPW'(1)));
    west9  = base9 + ((col9 == NPW'(0)) ? (best_cols_r - NPW'(1)) : (col9 - NPW'(1)));
    south9 = ((row9 + NPW'(1)) == best_rows_r) ? col9 : (rank9 + best_cols_r);
    north9 = (row9 == NPW'(0)) ? (p_r - best_cols_r + col9) : (rank9 - best_cols_r);
    sides  = {col9 != NPW'(0), row9 != NPW'(0),
              col9 != (best_cols_r - NPW'(1)), row9 != (best_rows_r - NPW'(1))};
  end

  assign rank_err = (NPW'(rank_r) >= p_r);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        rank_r  <= in_rank;
        p_r     <= p_cap;
        w_r     <= dim_w;
        h_r     <= dim_h;
        r_r     <= RW'(1);
        c_r     <= p_cap;
        rc_r    <= RW'(p_cap);
        first_r <= 1'b1;
      end
      OP_DEC_C: begin
        c_r  <= c_r - NPW'(1);
        rc_r <= rc_r - r_r;
      end
      OP_INC_R: begin
        r_r  <= r_r + RW'(1);
        rc_r <= rc_r + RW'(c_r);
      end
      OP_MUL_RH: prod_r <= mul_p;
      OP_MUL_CW: begin
        rh_r   <= prod_r[DVW-1:0];
        prod_r <= mul_p;
      end
      OP_ABSDIFF: begin
        d_r <= (rh_r >= prod_r[DVW-1:0]) ? (rh_r - prod_r[DVW-1:0]) :
                                           (prod_r[DVW-1:0] - rh_r);
      end
      OP_MUL_LHS: prod_r <= mul_p;
      OP_MUL_RHS: begin
        lhs_r  <= prod_r;
        prod_r <= mul_p;
      end
      OP_UPDATE: begin
        // ties go to the later, larger row count
        if (first_r || (lhs_r <= prod_r)) begin
          best_d_r    <= d_r;
          best_rows_r <= r_r[NPW-1:0];
          best_cols_r <= c_r;
        end
        first_r <= 1'b0;
        r_r     <= r_r + RW'(1);
        rc_r    <= rc_r + RW'(c_r);
      end
      OP_DIV_RANK, OP_DIV_X0, OP_DIV_X1, OP_DIV_Y0, OP_DIV_Y1: begin
        div_op_r <= cmd.op;
      end
      OP_FINISH: begin
        if (rank_err) begin
          row_out_r   <= '0;
          col_out_r   <= '0;
          east_out_r  <= '0;
          west_out_r  <= '0;
          south_out_r <= '0;
          north_out_r <= '0;
          tw_out_r    <= '0;
          th_out_r    <= '0;
          ox_out_r    <= '0;
          oy_out_r    <= '0;
          sides_out_r <= '0;
          err_out_r   <= 1'b1;
        end else begin
          row_out_r   <= row_r;
          col_out_r   <= col_r;
          east_out_r  <= east9[RANK_W-1:0];
          west_out_r  <= west9[RANK_W-1:0];
          south_out_r <= south9[RANK_W-1:0];
          north_out_r <= north9[RANK_W-1:0];
          tw_out_r    <= FIELD_W'(x1_r - x0_r);
          th_out_r    <= FIELD_W'(y1_r - y0_r);
          ox_out_r    <= FIELD_W'(x0_r);
          oy_out_r    <= FIELD_W'(y0_r);
          sides_out_r <= sides;
          err_out_r   <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // divider results
  always_ff @(posedge clk) begin
    if (div_done) begin
      unique case (div_op_r)
        OP_DIV_RANK: begin
          row_r <= div_quo[RANK_W-1:0];
          col_r <= div_rem[RANK_W-1:0];
        end
        OP_DIV_X0: x0_r <= div_quo[DW-1:0];
        OP_DIV_X1: x1_r <= div_quo[DW-1:0];
        OP_DIV_Y0: y0_r <= div_quo[DW-1:0];
        OP_DIV_Y1: y1_r <= div_quo[DW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign stat.rank_err = rank_err;
  assign stat.r_gt_p   = (r_r > RW'(p_r));
  assign stat.prod_gt  = (rc_r > RW'(p_r));
  assign stat.prod_eq  = (rc_r == RW'(p_r));
  assign stat.div_done = div_done;

  assign out_row_index      = row_out_r;
  assign out_col_index      = col_out_r;
  assign out_east_id        = east_out_r;
  assign out_west_id        = west_out_r;
  assign out_south_id       = south_out_r;
  assign out_north_id       = north_out_r;
  assign out_tile_width     = tw_out_r;
  assign out_tile_height    = th_out_r;
  assign out_origin_x       = ox_out_r;
  assign out_origin_y       = oy_out_r;
  assign out_interior_sides = sides_out_r;
  assign out_rank_error     = err_out_r;

endmodule

/* sv/gtd_ctrl.sv */
// controller: sequences search, divisions and result handshake
module gtd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output gtd_pkg::dp_cmd_t  cmd,
  input  gtd_pkg::dp_stat_t stat
);
  import gtd_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_CHECK    = 5'd1;
  localparam logic [4:0] S_SEARCH   = 5'd2;
  localparam logic [4:0] S_E_RH     = 5'd3;
  localparam logic [4:0] S_E_CW     = 5'd4;
  localparam logic [4:0] S_E_DIFF   = 5'd5;
  localparam logic [4:0] S_E_LHS    = 5'd6;
  localparam logic [4:0] S_E_RHS    = 5'd7;
  localparam logic [4:0] S_E_UPD    = 5'd8;
  localparam logic [4:0] S_DIV_RANK = 5'd9;
  localparam logic [4:0] S_W_RANK   = 5'd10;
  localparam logic [4:0] S_DIV_X0   = 5'd11;
  localparam logic [4:0] S_W_X0     = 5'd12;
  localparam logic [4:0] S_DIV_X1   = 5'd13;
  localparam logic [4:0] S_W_X1     = 5'd14;
  localparam logic [4:0] S_DIV_Y0   = 5'd15;
  localparam logic [4:0] S_W_Y0     = 5'd16;
  localparam logic [4:0] S_DIV_Y1   = 5'd17;
  localparam logic [4:0] S_W_Y1     = 5'd18;
  localparam logic [4:0] S_FINISH   = 5'd19;

  logic [4:0] state_r;
  logic [4:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_load;

  assign out_load = (state_r == S_FINISH) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: state_nxt = stat.rank_err ? S_FINISH : S_SEARCH;
      S_SEARCH: begin
        priority if (stat.r_gt_p) begin
          state_nxt = S_DIV_RANK;
        end else if (stat.prod_gt) begin
          cmd.op = OP_DEC_C;
        end else if (stat.prod_eq) begin
          state_nxt = S_E_RH;
        end else begin
          cmd.op = OP_INC_R;
        end
      end
      S_E_RH: begin
        cmd.op    = OP_MUL_RH;
        state_nxt = S_E_CW;
      end
      S_E_CW: begin
        cmd.op    = OP_MUL_CW;
        state_nxt = S_E_DIFF;
      end
      S_E_DIFF: begin
        cmd.op    = OP_ABSDIFF;
        state_nxt = S_E_LHS;
      end
      S_E_LHS: begin
        cmd.op    = OP_MUL_LHS;
        state_nxt = S_E_RHS;
      end
      S_E_RHS: begin
        cmd.op    = OP_MUL_RHS;
        state_nxt = S_E_UPD;
      end
      S_E_UPD: begin
        cmd.op    = OP_UPDATE;
        state_nxt = S_SEARCH;
      end
      S_DIV_RANK: begin
        cmd.op    = OP_DIV_RANK;
        state_nxt = S_W_RANK;
      end
      S_W_RANK: if (stat.div_done) state_nxt = S_DIV_X0;
      S_DIV_X0: begin
        cmd.op    = OP_DIV_X0;
        state_nxt = S_W_X0;
      end
      S_W_X0: if (stat.div_done) state_nxt = S_DIV_X1;
      S_DIV_X1: begin
        cmd.op    = OP_DIV_X1;
        state_nxt = S_W_X1;
      end
      S_W_X1: if (stat.div_done) state_nxt = S_DIV_Y0;
      S_DIV_Y0: begin
        cmd.op    = OP_DIV_Y0;
        state_nxt = S_W_Y0;
      end
      S_W_Y0: if (stat.div_done) state_nxt = S_DIV_Y1;
      S_DIV_Y1: begin
        cmd.op    = OP_DIV_Y1;
        state_nxt = S_W_Y1;
      end
      S_W_Y1: if (stat.div_done) state_nxt = S_FINISH;
      S_FINISH: begin
        if (out_load) begin
          cmd.op    = OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* sv/grid_tile_decomposer.sv */
// top level of the grid tile decomposer: configuration registers, controller, datapath
//
// Splits a grid_width x grid_height node grid over num_procs processors laid out
// as rows x cols (rows * cols == processor count, count capped at MAX_PROCS).
// The layout is the divisor pair whose rows/cols ratio lies closest to
// width/height, compared exactly by cross-multiplication; on a tie the larger
// row count wins. For each rank request the block returns row and column, the
// four wrap-around neighbour ranks, the tile size and origin and the interior
// side mask; a rank not below the processor count returns rank_error with all
// other fields zero. One request is worked at a time. The divisor search walks
// row counts 1..P keeping the column count and their product by add/subtract,
// one step a cycle, plus a pass through the shared multiplier (states S_E_RH
// to S_E_UPD) for each divisor pair found. Then five divisions run on a
// bit-serial divider of DIM+9 bits (rank by cols, then the two column and two
// row split points), DIM being min(DIM_WIDTH,16). An out of range rank skips the
// search and divisions and goes straight to the result. A new request is taken
// while the previous result still waits on out_stall. Configuration writes are
// always ready and are expected only while the block is idle.
module grid_tile_decomposer #(
  parameter int unsigned MAX_PROCS = 256,
  parameter int unsigned DIM_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gtd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gtd_pkg::CFG_DATA_W-1:0]   cfg_data,
  // rank requests
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [gtd_pkg::RANK_W-1:0]       in_rank,
  // tile placement results
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [gtd_pkg::RANK_W-1:0]       out_row_index,
  output logic [gtd_pkg::RANK_W-1:0]       out_col_index,
  output logic [gtd_pkg::RANK_W-1:0]       out_east_id,
  output logic [gtd_pkg::RANK_W-1:0]       out_west_id,
  output logic [gtd_pkg::RANK_W-1:0]       out_south_id,
  output logic [gtd_pkg::RANK_W-1:0]       out_north_id,
  output logic [gtd_pkg::FIELD_W-1:0]      out_tile_width,
  output logic [gtd_pkg::FIELD_W-1:0]      out_tile_height,
  output logic [gtd_pkg::FIELD_W-1:0]      out_origin_x,
  output logic [gtd_pkg::FIELD_W-1:0]      out_origin_y,
  output logic [gtd_pkg::SIDES_W-1:0]      out_interior_sides,
  output logic                             out_rank_error
);
  import gtd_pkg::*;

  // grid dimensions are used in their low DW bits, DW being DIM_WIDTH capped at FIELD_W
  localparam int unsigned DW = (DIM_WIDTH < FIELD_W) ? DIM_WIDTH : FIELD_W;

  logic [NPW-1:0]     num_procs_r;
  logic [FIELD_W-1:0] grid_width_r;
  logic [FIELD_W-1:0] grid_height_r;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // config writes are never held off
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_procs_r   <= NPW'(1);
      grid_width_r  <= FIELD_W'(1);
      grid_height_r <= FIELD_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUM_PROCS:   num_procs_r   <= cfg_data[NPW-1:0];
        REG_GRID_WIDTH:  grid_width_r  <= cfg_data[FIELD_W-1:0];
        REG_GRID_HEIGHT: grid_height_r <= cfg_data[FIELD_W-1:0];
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // sequencing: search loop, divider waits, result hand-off
  gtd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // search registers, multiplier, divider and the result register
  gtd_dp #(
    .MAX_PROCS(MAX_PROCS),
    .DW       (DW)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_rank           (in_rank),
    .num_procs         (num_procs_r),
    .dim_w             (grid_width_r[DW-1:0]),
    .dim_h             (grid_height_r[DW-1:0]),
    .out_row_index     (out_row_index),
    .out_col_index     (out_col_index),
    .out_east_id       (out_east_id),
    .out_west_id       (out_west_id),
    .out_south_id      (out_south_id),
    .out_north_id      (out_north_id),
    .out_tile_width    (out_tile_width),
    .out_tile_height   (out_tile_height),
    .out_origin_x      (out_origin_x),
    .out_origin_y      (out_origin_y),
    .out_interior_sides(out_interior_sides),
    .out_rank_error    (out_rank_error)
  );

endmodule

/* tb/tb_grid_tile_decomposer.sv */
// self-checking testbench of the grid tile decomposer: directed and random rank requests
module tb_grid_tile_decomposer;
  import gtd_pkg::*;

  localparam int unsigned MAX_P      = 256;
  localparam int unsigned DIM_W      = 16;
  localparam int unsigned STALL_PCT  = 19;     // idle share of each side, percent
  localparam int unsigned RAND_ITEMS = 700;
  localparam int unsigned DRAIN_GAP  = 40;     // settle cycles before a register write
  localparam int unsigned WATCHDOG   = 20000;  // cycles with no handshake at all

  // spare register index, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // one tile placement result
  typedef struct packed {
    logic [RANK_W-1:0]  row_index;
    logic [RANK_W-1:0]  col_index;
    logic [RANK_W-1:0]  east_id;
    logic [RANK_W-1:0]  west_id;
    logic [RANK_W-1:0]  south_id;
    logic [RANK_W-1:0]  north_id;
    logic [FIELD_W-1:0] tile_width;
    logic [FIELD_W-1:0] tile_height;
    logic [FIELD_W-1:0] origin_x;
    logic [FIELD_W-1:0] origin_y;
    logic [SIDES_W-1:0] interior_sides;
    logic               rank_error;
  } tile_t;

  // clock, reset and every block input start at a known value
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [RANK_W-1:0]     in_rank   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [RANK_W-1:0]     out_row_index, out_col_index;
  logic [RANK_W-1:0]     out_east_id, out_west_id, out_south_id, out_north_id;
  logic [FIELD_W-1:0]    out_tile_width, out_tile_height, out_origin_x, out_origin_y;
  logic [SIDES_W-1:0]    out_interior_sides;
  logic                  out_rank_error;

  // testbench copy of the configuration registers, reset values
  logic [NPW-1:0]        cur_procs  = 9'd1;
  logic [FIELD_W-1:0]    cur_width  = 16'd1;
  logic [FIELD_W-1:0]    cur_height = 16'd1;

  logic [RANK_W-1:0]     rank_q[$];     // ranks waiting to be sent
  tile_t                 placement_q[$];  // predicted placements, oldest first
  logic                  steady = 1'b0;  // no idling on either side while set

  int unsigned           errors      = 0;
  int unsigned           n_requests  = 0;
  int unsigned           n_results   = 0;
  int unsigned           n_rank_errs = 0;
  int unsigned           n_configs   = 0;
  int unsigned           quiet_cycles = 0;

  grid_tile_decomposer #(
    .MAX_PROCS(MAX_P),
    .DIM_WIDTH(DIM_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rank           (in_rank),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_row_index     (out_row_index),
    .out_col_index     (out_col_index),
    .out_east_id       (out_east_id),
    .out_west_id       (out_west_id),
    .out_south_id      (out_south_id),
    .out_north_id      (out_north_id),
    .out_tile_width    (out_tile_width),
    .out_tile_height   (out_tile_height),
    .out_origin_x      (out_origin_x),
    .out_origin_y      (out_origin_y),
    .out_interior_sides(out_interior_sides),
    .out_rank_error    (out_rank_error)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned gap_of(longint unsigned a, longint unsigned b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // expected placement of a rank under the current register copy
  function automatic tile_t place_rank(logic [RANK_W-1:0] rank);
    longint unsigned p, w, h, rows, cols, best, d, c, i;
    longint unsigned row, col, x0, x1, y0, y1;
    tile_t t;
    t = '0;
    p = cur_procs;
    w = cur_width;
    h = cur_height;
    // counts above the cap fold down to the cap
    if (p > MAX_P) p = MAX_P;
    // out of range rank, zero processors included: flag only
    if (rank >= p) begin
      t.rank_error = 1'b1;
      return t;
    end
    // divisor search, ratio distance |r*h - c*w| / c compared by cross-multiplying,
    // less-or-equal replaces so the larger row count wins a tie
    rows = 1;
    cols = p;
    best = gap_of(h, p * w);
    for (i = 2; i <= p; i++) begin
      if (p % i == 0) begin
        c = p / i;
        d = gap_of(i * h, c * w);
        if (d * cols <= best * c) begin
          best = d;
          rows = i;
          cols = c;
        end
      end
    end
    row = rank / cols;
    col = rank % cols;
    x0  = (col * w) / cols;
    x1  = ((col + 1) * w) / cols;
    y0  = (row * h) / rows;
    y1  = ((row + 1) * h) / rows;
    t.row_index      = row[RANK_W-1:0];
    t.col_index      = col[RANK_W-1:0];
    t.east_id        = RANK_W'(row * cols + (col + 1) % cols);
    t.west_id        = RANK_W'(row * cols + (col + cols - 1) % cols);
    t.south_id       = RANK_W'(cols * ((row + 1) % rows) + col);
    t.north_id       = RANK_W'(cols * ((row + rows - 1) % rows) + col);
    t.tile_width     = FIELD_W'(x1 - x0);
    t.tile_height    = FIELD_W'(y1 - y0);
    t.origin_x       = x0[FIELD_W-1:0];
    t.origin_y       = y0[FIELD_W-1:0];
    t.interior_sides = {col != 0, row != 0, col != cols - 1, row != rows - 1};
    return t;
  endfunction

  // one field compare, mismatch goes to the log with time, expected and actual
  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // register write, waits for the handshake and then mirrors the value
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_NUM_PROCS:   cur_procs  = data[NPW-1:0];
      REG_GRID_WIDTH:  cur_width  = data;
      REG_GRID_HEIGHT: cur_height = data;
      default: ;
    endcase
  endtask

  // full configuration of one phase
  task automatic set_grid(logic [CFG_DATA_W-1:0] p, logic [CFG_DATA_W-1:0] w,
                          logic [CFG_DATA_W-1:0] h);
    write_reg(REG_NUM_PROCS, p);
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    n_configs++;
  endtask

  // wait until every queued request is sent and answered, then let the block settle;
  // sampled between edges so the driver's updates of that edge have landed
  task automatic drain();
    while (rank_q.size() != 0 || in_valid || placement_q.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // random grid dimension, extremes and small values weighted up
  function automatic logic [FIELD_W-1:0] pick_dim();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5) return '0;
    if (sel < 12) return '1;
    if (sel < 55) return FIELD_W'($urandom_range(1, 200));
    return FIELD_W'($urandom_range(0, 65535));
  endfunction

  // random processor count, mostly small to keep the divisor search short
  function automatic logic [CFG_DATA_W-1:0] pick_procs();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 3) return '0;
    if (sel < 70) return CFG_DATA_W'($urandom_range(1, 64));
    if (sel < 88) return CFG_DATA_W'($urandom_range(65, 255));
    if (sel < 92) return CFG_DATA_W'(MAX_P);
    // raw 16-bit data, only the low bits land in the register
    return CFG_DATA_W'($urandom_range(0, 65535));
  endfunction

  // mostly in-range ranks, the rest spread over the whole field
  function automatic logic [RANK_W-1:0] pick_rank();
    int unsigned p;
    p = (cur_procs > MAX_P) ? MAX_P : cur_procs;
    if (p > 0 && $urandom_range(99) < 85) return RANK_W'($urandom_range(0, p - 1));
    return RANK_W'($urandom_range(0, 255));
  endfunction

  // request driver: predicts at acceptance, loads the next rank after a random gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      logic taken;
      taken = in_valid && !in_stall;
      if (taken) begin
        placement_q.push_back(place_rank(in_rank));
        n_requests++;
      end
      if (!in_valid || taken) begin
        if (rank_q.size() != 0 && (steady || $urandom_range(99) >= STALL_PCT)) begin
          in_rank  <= rank_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: random back-pressure, every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      tile_t got, want;
      if (out_valid && !out_stall) begin
        got = '{out_row_index, out_col_index, out_east_id, out_west_id, out_south_id,
                out_north_id, out_tile_width, out_tile_height, out_origin_x, out_origin_y,
                out_interior_sides, out_rank_error};
        n_results++;
        if (placement_q.size() == 0) begin
          errors++;
          $display("%0t: result with no request pending, row %0d col %0d err %0b",
                   $time, got.row_index, got.col_index, got.rank_error);
        end else begin
          want = placement_q.pop_front();
          if (want.rank_error) n_rank_errs++;
          check_field("row_index", want.row_index, got.row_index);
          check_field("col_index", want.col_index, got.col_index);
          check_field("east_id", want.east_id, got.east_id);
          check_field("west_id", want.west_id, got.west_id);
          check_field("south_id", want.south_id, got.south_id);
          check_field("north_id", want.north_id, got.north_id);
          check_field("tile_width", want.tile_width, got.tile_width);
          check_field("tile_height", want.tile_height, got.tile_height);
          check_field("origin_x", want.origin_x, got.origin_x);
          check_field("origin_y", want.origin_y, got.origin_y);
          check_field("interior_sides", want.interior_sides, got.interior_sides);
          check_field("rank_error", want.rank_error, got.rank_error);
        end
      end
      out_stall <= steady ? 1'b0 : ($urandom_range(99) < STALL_PCT);
    end
  end

  // watchdog: any handshake on any channel restarts the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // stimulus sequencer: directed phases, then random phases, each drained before its writes
  initial begin
    int unsigned phase_no;
    int unsigned n;
    int unsigned queued;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration, one processor on a one-node grid, plus out of range ranks
    rank_q.push_back(8'd0);
    rank_q.push_back(8'd1);
    rank_q.push_back(8'd255);
    drain();

    // 4:3 grid on twelve processors, corners of the layout and the first bad rank
    set_grid(16'd12, 16'd640, 16'd480);
    rank_q.push_back(8'd0);
    rank_q.push_back(8'd5);
    rank_q.push_back(8'd11);
    rank_q.push_back(8'd12);
    drain();

    // largest count, largest grid
    set_grid(16'd256, 16'hFFFF, 16'hFFFF);
    rank_q.push_back(8'd0);
    rank_q.push_back(8'd255);
    rank_q.push_back(8'd128);
    rank_q.push_back(8'd17);
    drain();

    // zero processors, every rank out of range
    set_grid(16'd0, 16'd1, 16'd1);
    rank_q.push_back(8'd0);
    rank_q.push_back(8'd200);
    drain();

    // count above the cap, all data bits set, folds down to the cap
    set_grid(16'hFFFF, 16'd1000, 16'd7);
    rank_q.push_back(8'd255);
    rank_q.push_back(8'd3);
    drain();

    // zero height, every candidate ties
    set_grid(16'd6, 16'd100, 16'd0);
    rank_q.push_back(8'd0);
    rank_q.push_back(8'd2);
    rank_q.push_back(8'd5);
    drain();

    // zero width, empty tiles; spare index write must leave the registers alone
    set_grid(16'd4, 16'd0, 16'd50);
    write_reg(REG_SPARE, 16'hA5C3);
    rank_q.push_back(8'd0);
    rank_q.push_back(8'd3);
    drain();

    // prime count on a tall grid, single column or row layout
    set_grid(16'd13, 16'd1, 16'hFFFF);
    rank_q.push_back(8'd0);
    rank_q.push_back(8'd12);
    drain();

    // random phases, some registers kept from the previous phase
    queued   = 0;
    phase_no = 0;
    while (queued < RAND_ITEMS) begin
      if (phase_no == 0 || $urandom_range(99) < 80)
        write_reg(REG_NUM_PROCS, pick_procs());
      if (phase_no == 0 || $urandom_range(99) < 75)
        write_reg(REG_GRID_WIDTH, pick_dim());
      if (phase_no == 0 || $urandom_range(99) < 75)
        write_reg(REG_GRID_HEIGHT, pick_dim());
      if ($urandom_range(99) < 10)
        write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 65535)));
      n_configs++;
      // one phase in seven runs with both sides always ready
      steady = (phase_no % 7 == 3);
      n = (cur_procs > 128 && cur_procs <= MAX_P) ? $urandom_range(4, 12)
                                                  : $urandom_range(10, 40);
      repeat (n) rank_q.push_back(pick_rank());
      queued += n;
      drain();
      steady = 1'b0;
      phase_no++;
    end

    // all requests answered; anything left over is a failure
    drain();
    if (placement_q.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted results never arrived", $time, placement_q.size());
    end
    $display("covered %0d rank requests over %0d register settings", n_requests, n_configs);
    $display("%0d results checked, %0d of them out of range ranks", n_results, n_rank_errs);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
